### rtl/core/pai_pkg.sv
// pai_pkg: shared types and constants for the positional insert/delete list
// used by pai_cell and positional_array_insert_delete; no dependencies
package pai_pkg;

  localparam int DEPTH  = 32;
  localparam int DATA_W = 32;
  localparam int POS_W  = 6;
  localparam int REQ_W  = 2;
  localparam int ST_W   = 2;
  localparam int OCNT_W = 6;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_READ   = 2'd2
  } req_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    logic load;
    logic shift_up;
    logic shift_down;
  } cell_ctl_t;

endpackage

### rtl/core/positional_array_insert_delete.sv
// positional_array_insert_delete: top level of the positional insert/delete list
// a row of pai_cell instances plus count, request decode and result register
// depends on pai_pkg and pai_cell
//
// usage:
//   input channel: in_valid_i / in_stall_o with req_type_i, position_i, value_i
//   (insert, delete or read at a position); output channel: out_valid_o /
//   out_stall_i with status_o, count_o, data_o
//   a transaction moves at a clock edge where valid is high and stall is low
//   every request gives exactly one result, registered in the cycle after the
//   request transaction; one request per cycle is sustained while the receiver
//   does not stall, as every cell of the row shifts, loads or holds in the same cycle
//   when the receiver stalls, the result register holds and in_stall_o is
//   raised, so no further request is taken until the result moves
//   reset clears the entry count and the result valid; cell contents stay
//   undefined, but only entries below the count are ever read
module positional_array_insert_delete
  import pai_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [REQ_W-1:0]  req_type_i,
  input  logic [POS_W-1:0]  position_i,
  input  logic [DATA_W-1:0] value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ST_W-1:0]   status_o,
  output logic [OCNT_W-1:0] count_o,
  output logic [DATA_W-1:0] data_o
);

  logic [CNT_W-1:0]  count_q, count_d;
  logic              out_valid_q, out_valid_d;
  logic [ST_W-1:0]   status_q;
  logic [OCNT_W-1:0] ocount_q;
  logic [DATA_W-1:0] data_q;

  logic              in_accept;
  logic              ins_ok, del_ok;
  status_e           status_c;
  logic [DATA_W-1:0] data_c;
  logic [CMP_W-1:0]  pos_c, cnt_c;
  logic [IDX_W-1:0]  rd_idx;
  logic [DATA_W-1:0] rd_data;
  logic [DATA_W-1:0] cell_data [DEPTH];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign pos_c   = CMP_W'(position_i);
  assign cnt_c   = CMP_W'(count_q);
  assign rd_idx  = IDX_W'(position_i);
  assign rd_data = cell_data[rd_idx];

  // request decode
  always_comb begin
    ins_ok   = 1'b0;
    del_ok   = 1'b0;
    status_c = ST_OK;
    data_c   = '0;
    unique case (req_e'(req_type_i))
      REQ_INSERT: begin
        if (count_q == CNT_W'(DEPTH)) begin
          status_c = ST_FULL;
        end else if (pos_c > cnt_c) begin
          status_c = ST_RANGE;
        end else begin
          ins_ok = 1'b1;
        end
      end
      REQ_DELETE: begin
        if (pos_c >= cnt_c) begin
          status_c = ST_RANGE;
        end else begin
          del_ok = 1'b1;
          data_c = rd_data;
        end
      end
      REQ_READ: begin
        if (pos_c >= cnt_c) begin
          status_c = ST_RANGE;
        end else begin
          data_c = rd_data;
        end
      end
      default: begin
        status_c = ST_OK;
      end
    endcase
  end

  // row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctl_t         ctl;
    logic [DATA_W-1:0] left_data;
    logic [DATA_W-1:0] right_data;

    assign ctl.load       = in_accept && ins_ok && (pos_c == CMP_W'(i));
    assign ctl.shift_up   = in_accept && ins_ok && (pos_c < CMP_W'(i));
    assign ctl.shift_down = in_accept && del_ok && (pos_c <= CMP_W'(i));

    if (i == 0) begin : g_first
      assign left_data = value_i;
    end else begin : g_left
      assign left_data = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_data = value_i;
    end else begin : g_right
      assign right_data = cell_data[i+1];
    end

    pai_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .ins_data_i   (value_i),
      .left_data_i  (left_data),
      .right_data_i (right_data),
      .data_o       (cell_data[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (in_accept && ins_ok) begin
      count_d = count_q + CNT_W'(1);
    end else if (in_accept && del_ok) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      status_q <= status_c;
      ocount_q <= OCNT_W'(count_d);
      data_q   <= data_c;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign count_o     = ocount_q;
  assign data_o      = data_q;

endmodule

### rtl/core/pai_cell.sv
// pai_cell: one storage cell of the list, holds one entry
// loads a new value, takes its left or right neighbor, or holds; uses pai_pkg
module pai_cell
  import pai_pkg::*;
(
  input  logic              clk_i,
  input  cell_ctl_t         ctl_i,
  input  logic [DATA_W-1:0] ins_data_i,
  input  logic [DATA_W-1:0] left_data_i,
  input  logic [DATA_W-1:0] right_data_i,
  output logic [DATA_W-1:0] data_o
);

  logic [DATA_W-1:0] data_q;
  logic [DATA_W-1:0] data_d;

  always_comb begin
    priority if (ctl_i.load) begin
      data_d = ins_data_i;
    end else if (ctl_i.shift_up) begin
      data_d = left_data_i;
    end else if (ctl_i.shift_down) begin
      data_d = right_data_i;
    end else begin
      data_d = data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule
